>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stlb_pkg.sv
// ----------------------------------------------------------------------------
// stlb_pkg
// Types, constants and helpers shared by the scrolling text line buffer.
// ----------------------------------------------------------------------------
package stlb_pkg;

	// Screen geometry
	localparam int LINES        = 50;
	localparam int COLUMNS      = 26;
	localparam int VISIBLE_ROWS = 15;
	localparam int CELLS        = LINES * COLUMNS;

	// Field and index widths
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 5;
	localparam int LINE_W = $clog2(LINES);
	localparam int ADDR_W = $clog2(CELLS);

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] CH_K         = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

	// Small two-entry queues
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;
	localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

	// Command classes produced by the front end
	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_NEWLINE,
		CMD_BKSP,
		CMD_KEY_K,
		CMD_READ,
		CMD_READ_BLANK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] chr;
		logic [COL_W-1:0]  column;
		logic              skip;
	} result_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_PUT,
		BK_READ
	} back_state_t;

	// Flat store address of a cell
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] line,
			input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(line) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

>>> rtl/core/stlb_front.sv
// ----------------------------------------------------------------------------
// stlb_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stlb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [stlb_pkg::BYTE_W-1:0] rx_byte,
	input  logic [stlb_pkg::ROW_W-1:0]  view_row,
	input  logic [stlb_pkg::COL_W-1:0]  view_column,
	input  logic                        init_busy,
	output logic                        cmd_valid,
	output stlb_pkg::cmd_t              cmd,
	input  logic                        cmd_pop
);

	stlb_pkg::cmd_t                  cls;
	stlb_pkg::cmd_t                  cq_q [stlb_pkg::Q_DEPTH];
	logic [stlb_pkg::Q_PTR_W-1:0]    wp_q;
	logic [stlb_pkg::Q_PTR_W-1:0]    rp_q;
	logic [stlb_pkg::Q_CNT_W-1:0]    cnt_q;
	logic                            accept;

	function automatic logic [stlb_pkg::Q_CNT_W-1:0] Q_CNT_INC(input logic b);
		Q_CNT_INC = {{(stlb_pkg::Q_CNT_W-1){1'b0}}, b};
	endfunction

	// Classify the incoming transaction
	always_comb begin
		cls.data = rx_byte;
		cls.row  = view_row;
		cls.col  = view_column;
		if (opcode) begin
			if (view_row >= stlb_pkg::ROW_W'(stlb_pkg::VISIBLE_ROWS) ||
					view_column >= stlb_pkg::COL_W'(stlb_pkg::COLUMNS)) begin
				cls.kind = stlb_pkg::CMD_READ_BLANK;
			end else begin
				cls.kind = stlb_pkg::CMD_READ;
			end
		end else if (rx_byte == stlb_pkg::CH_NEWLINE) begin
			cls.kind = stlb_pkg::CMD_NEWLINE;
		end else if (rx_byte == stlb_pkg::CH_BACKSPACE) begin
			cls.kind = stlb_pkg::CMD_BKSP;
		end else if (rx_byte == stlb_pkg::CH_K) begin
			cls.kind = stlb_pkg::CMD_KEY_K;
		end else begin
			cls.kind = stlb_pkg::CMD_PRINT;
		end
	end

	// Hold off input while the queue is full or the store is swept after reset
	assign full   = (cnt_q == stlb_pkg::Q_FULL) || init_busy;
	assign accept = push && !full;

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) wp_q <= wp_q + 1'b1;
			if (cmd_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + Q_CNT_INC(accept) - Q_CNT_INC(cmd_pop);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept) cq_q[wp_q] <= cls;
	end

	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rp_q];

	`ASSERT_IMPLIES(a_pop_has_data, clk, arst_n, cmd_pop, cnt_q != '0, "command pop from empty queue")
	`ASSERT_IMPLIES(a_no_take_in_init, clk, arst_n, init_busy, !accept, "transaction taken during store sweep")

endmodule

>>> rtl/core/stlb_back.sv
// ----------------------------------------------------------------------------
// stlb_back
// Executes queued commands against the character store and queues results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stlb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  stlb_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	output logic                        init_busy,
	output logic                        empty,
	input  logic                        pop,
	output logic [stlb_pkg::BYTE_W-1:0] cell_char,
	output logic [stlb_pkg::COL_W-1:0]  cursor_column,
	output logic                        skipping
);

	// Character store
	logic [stlb_pkg::BYTE_W-1:0] mem_q [stlb_pkg::CELLS];
	logic                        mem_we;
	logic [stlb_pkg::ADDR_W-1:0] mem_waddr;
	logic [stlb_pkg::BYTE_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [stlb_pkg::ADDR_W-1:0] mem_raddr;
	logic [stlb_pkg::BYTE_W-1:0] rdata_q;

	// Screen state
	stlb_pkg::back_state_t       state_q, state_d;
	logic [stlb_pkg::LINE_W-1:0] newest_q, newest_d;
	logic [stlb_pkg::COL_W-1:0]  wc_q, wc_d;
	logic                        skip_q, skip_d;
	logic [stlb_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
	logic [stlb_pkg::ADDR_W-1:0] clr_end_q, clr_end_d;
	logic                        put_pend_q, put_pend_d;
	logic [stlb_pkg::BYTE_W-1:0] put_byte_q, put_byte_d;

	// Result queue
	stlb_pkg::result_t            rq_q [stlb_pkg::Q_DEPTH];
	logic [stlb_pkg::Q_PTR_W-1:0] rwp_q;
	logic [stlb_pkg::Q_PTR_W-1:0] rrp_q;
	logic [stlb_pkg::Q_CNT_W-1:0] rcnt_q;
	logic                         res_push;
	stlb_pkg::result_t            res_data;
	logic                         res_pop;

	// Helpers
	logic [stlb_pkg::LINE_W-1:0] prev_line;
	logic [stlb_pkg::LINE_W:0]   view_sum;
	logic [stlb_pkg::LINE_W-1:0] view_line;
	logic                        clr_last;
	logic                        dispatch;

	assign prev_line = (newest_q == '0) ? stlb_pkg::LINE_W'(stlb_pkg::LINES - 1)
	                                    : newest_q - 1'b1;
	assign view_sum  = {1'b0, newest_q} + (stlb_pkg::LINE_W+1)'(cmd.row);
	assign view_line = (view_sum >= (stlb_pkg::LINE_W+1)'(stlb_pkg::LINES))
	                   ? stlb_pkg::LINE_W'(view_sum - (stlb_pkg::LINE_W+1)'(stlb_pkg::LINES))
	                   : stlb_pkg::LINE_W'(view_sum);
	assign clr_last  = (clr_addr_q == clr_end_q);
	assign dispatch  = cmd_valid && (rcnt_q != stlb_pkg::Q_FULL);
	assign init_busy = (state_q == stlb_pkg::BK_INIT);

	// Sequencer: next state, store access and result push
	always_comb begin
		state_d    = state_q;
		newest_d   = newest_q;
		wc_d       = wc_q;
		skip_d     = skip_q;
		clr_addr_d = clr_addr_q;
		clr_end_d  = clr_end_q;
		put_pend_d = put_pend_q;
		put_byte_d = put_byte_q;
		mem_we     = 1'b0;
		mem_waddr  = clr_addr_q;
		mem_wdata  = stlb_pkg::CH_SPACE;
		mem_re     = 1'b0;
		mem_raddr  = stlb_pkg::cell_addr(view_line, cmd.col);
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_data   = '{chr: '0, column: wc_q, skip: skip_q};

		unique case (state_q)
			stlb_pkg::BK_INIT: begin
				mem_we     = 1'b1;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_last) state_d = stlb_pkg::BK_IDLE;
			end
			stlb_pkg::BK_IDLE: begin
				if (dispatch) begin
					cmd_pop = 1'b1;
					if (cmd.kind == stlb_pkg::CMD_READ) begin
						mem_re  = 1'b1;
						state_d = stlb_pkg::BK_READ;
					end else if (cmd.kind == stlb_pkg::CMD_READ_BLANK) begin
						res_push     = 1'b1;
						res_data.chr = stlb_pkg::CH_SPACE;
					end else if (skip_q) begin
						// Skip mode: only 'K' ends it, with a destructive backspace
						if (cmd.kind == stlb_pkg::CMD_KEY_K) begin
							skip_d = 1'b0;
							if (wc_q != '0) begin
								wc_d      = wc_q - 1'b1;
								mem_we    = 1'b1;
								mem_waddr = stlb_pkg::cell_addr(newest_q, wc_q - 1'b1);
							end
						end
						res_push        = 1'b1;
						res_data.column = wc_d;
						res_data.skip   = skip_d;
					end else if (cmd.kind == stlb_pkg::CMD_BKSP) begin
						skip_d        = 1'b1;
						res_push      = 1'b1;
						res_data.skip = 1'b1;
					end else if (cmd.kind == stlb_pkg::CMD_NEWLINE ||
							wc_q >= stlb_pkg::COL_W'(stlb_pkg::COLUMNS)) begin
						// Recycle the oldest line, then optionally put the byte
						newest_d   = prev_line;
						wc_d       = '0;
						clr_addr_d = stlb_pkg::cell_addr(prev_line, '0);
						clr_end_d  = stlb_pkg::cell_addr(prev_line,
						             stlb_pkg::COL_W'(stlb_pkg::COLUMNS - 1));
						put_pend_d = (cmd.kind != stlb_pkg::CMD_NEWLINE);
						put_byte_d = cmd.data;
						state_d    = stlb_pkg::BK_CLEAR;
					end else begin
						mem_we          = 1'b1;
						mem_waddr       = stlb_pkg::cell_addr(newest_q, wc_q);
						mem_wdata       = cmd.data;
						wc_d            = wc_q + 1'b1;
						res_push        = 1'b1;
						res_data.column = wc_d;
					end
				end
			end
			stlb_pkg::BK_CLEAR: begin
				mem_we     = 1'b1;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_last) begin
					if (put_pend_q) begin
						state_d = stlb_pkg::BK_PUT;
					end else begin
						res_push = 1'b1;
						state_d  = stlb_pkg::BK_IDLE;
					end
				end
			end
			stlb_pkg::BK_PUT: begin
				mem_we          = 1'b1;
				mem_waddr       = stlb_pkg::cell_addr(newest_q, '0);
				mem_wdata       = put_byte_q;
				wc_d            = stlb_pkg::COL_W'(1);
				res_push        = 1'b1;
				res_data.column = wc_d;
				state_d         = stlb_pkg::BK_IDLE;
			end
			stlb_pkg::BK_READ: begin
				res_push     = 1'b1;
				res_data.chr = rdata_q;
				state_d      = stlb_pkg::BK_IDLE;
			end
			default: begin
				state_d = stlb_pkg::BK_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= stlb_pkg::BK_INIT;
			newest_q   <= '0;
			wc_q       <= '0;
			skip_q     <= 1'b0;
			clr_addr_q <= '0;
			clr_end_q  <= stlb_pkg::ADDR_W'(stlb_pkg::CELLS - 1);
			put_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			newest_q   <= newest_d;
			wc_q       <= wc_d;
			skip_q     <= skip_d;
			clr_addr_q <= clr_addr_d;
			clr_end_q  <= clr_end_d;
			put_pend_q <= put_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		put_byte_q <= put_byte_d;
	end

	// Store write port
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
	end

	// Store read port, registered
	always_ff @(posedge clk) begin
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	// Result queue control
	assign res_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q  <= '0;
			rrp_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (res_push) rwp_q <= rwp_q + 1'b1;
			if (res_pop) rrp_q <= rrp_q + 1'b1;
			rcnt_q <= rcnt_q + stlb_pkg::Q_CNT_W'(res_push) - stlb_pkg::Q_CNT_W'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) rq_q[rwp_q] <= res_data;
	end

	assign empty         = (rcnt_q == '0);
	assign cell_char     = rq_q[rrp_q].chr;
	assign cursor_column = rq_q[rrp_q].column;
	assign skipping      = rq_q[rrp_q].skip;

	`ASSERT_ALWAYS(a_wc_range, clk, arst_n, wc_q <= stlb_pkg::COL_W'(stlb_pkg::COLUMNS), "cursor past line end")
	`ASSERT_IMPLIES(a_push_room, clk, arst_n, res_push, rcnt_q != stlb_pkg::Q_FULL, "result pushed into full queue")
	`ASSERT_NEXT(a_put_after_clear, clk, arst_n, state_q == stlb_pkg::BK_CLEAR && clr_last && put_pend_q, state_q == stlb_pkg::BK_PUT, "pending byte lost after line clear")

endmodule

>>> rtl/core/scrolling_text_line_buffer.sv
// ----------------------------------------------------------------------------
// scrolling_text_line_buffer
// Ring of text lines fed by received bytes, with single-cell read back.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive opcode/rx_byte/view_row/view_column and
//   raise push; the transaction is taken on a clock edge with push high and
//   full low. Opcode 0 feeds a received byte, opcode 1 reads one displayed
//   cell (row 0 is the newest line).
//   Result side is a queue: while empty is low the oldest result sits on
//   cell_char/cursor_column/skipping; pop high on a clock edge takes it.
//   Every transaction yields exactly one result, in order.
// Execution (from the command reaching the executor):
//   plain byte, backspace, skip-mode byte, off-screen read: result pushed on dispatch
//   on-screen read: registered store read, then the result
//   newline: line clear, then the result; byte wrapping to a new line: line clear, then put
//   The one-per-cycle line clear is the longest step.
// Reset: the whole store is swept to spaces, one cell a cycle, over all
//   LINES*COLUMNS = 1300 cells; full stays high during the sweep.
// A stalled receiver fills the two-entry result queue, after which the
//   executor stops dispatching and the two-entry command queue fills.
// ----------------------------------------------------------------------------

module scrolling_text_line_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [stlb_pkg::BYTE_W-1:0] rx_byte,
	input  logic [stlb_pkg::ROW_W-1:0]  view_row,
	input  logic [stlb_pkg::COL_W-1:0]  view_column,
	output logic                        empty,
	input  logic                        pop,
	output logic [stlb_pkg::BYTE_W-1:0] cell_char,
	output logic [stlb_pkg::COL_W-1:0]  cursor_column,
	output logic                        skipping
);

	logic           cmd_valid;
	stlb_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           init_busy;

	// Front end: accept and classify
	stlb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.view_row    (view_row),
		.view_column (view_column),
		.init_busy   (init_busy),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// Back end: execute against the store
	stlb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.init_busy     (init_busy),
		.empty         (empty),
		.pop           (pop),
		.cell_char     (cell_char),
		.cursor_column (cursor_column),
		.skipping      (skipping)
	);

endmodule
